// File: rtl/bba_pkg.sv
// Shared types, constants and index helpers for the buddy block allocator.
// Used by the interfaces, the controller, the datapath and the top level.
// No dependencies.
package bba_pkg;

  localparam int MAX_LOG2   = 16;
  localparam int MIN_LOG2   = 4;
  localparam int LINK_BYTES = 16;

  localparam int BLK_W      = MAX_LOG2 - MIN_LOG2;
  localparam int NUM_BLOCKS = 1 << BLK_W;
  localparam int BUCKETS    = BLK_W + 1;
  localparam int BKT_W      = $clog2(BUCKETS);
  localparam int NODE_W     = BLK_W + 1;
  localparam int OFF_W      = MAX_LOG2;
  localparam int SIZE_W     = MAX_LOG2 + 1;
  localparam int CMP_W      = SIZE_W + 1;

  localparam logic [SIZE_W-1:0] SPAN_BYTES = SIZE_W'(1) << MAX_LOG2;

  localparam logic [1:0] RES_OK       = 2'd0;
  localparam logic [1:0] RES_TOO_BIG  = 2'd1;
  localparam logic [1:0] RES_NO_SPACE = 2'd2;
  localparam logic [1:0] RES_BAD_LEN  = 2'd3;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_LOAD,
    OP_PUSH_A,
    OP_PUSH_B,
    OP_RD_LINK,
    OP_RM_WR,
    OP_RD_FLAG,
    OP_FLIP,
    OP_INIT,
    OP_G_SETUP,
    OP_G_SPLIT,
    OP_G_DEC,
    OP_A_TGT,
    OP_A_TGT2,
    OP_B_DEC,
    OP_A_POP,
    OP_A_UNDO,
    OP_A_NODE,
    OP_A_SPLIT,
    OP_F_SET,
    OP_F_SIB,
    OP_F_UP,
    OP_F_END,
    OP_RESULT
  } bba_op_e;

  typedef struct packed {
    bba_op_e    op;
    logic [1:0] code;
  } bba_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic big;
    logic act;
    logic grow_more;
    logic flag_rd;
    logic right_fail;
    logic root_nz;
    logic pop_empty;
    logic b_zero;
    logic b_is_root;
    logic fit;
    logic i_nz;
    logic b_lt_want;
    logic free_more;
    logic flag_new;
  } bba_stat_t;

  function automatic logic [NODE_W-1:0] root_node(input logic [BKT_W-1:0] b);
    logic [NODE_W:0] one;
    one = (NODE_W+1)'(1) << b;
    return NODE_W'(one - 1'b1);
  endfunction

  function automatic logic [NODE_W-1:0] head_node(input logic [BKT_W-1:0] b);
    return {1'b1, BLK_W'(b)};
  endfunction

  function automatic logic [BLK_W-1:0] parent_slot(input logic [NODE_W-1:0] i);
    logic [NODE_W-1:0] d;
    d = i - 1'b1;
    return d[NODE_W-1:1];
  endfunction

  function automatic logic [NODE_W-1:0] node_of_blk(input logic [BLK_W-1:0] blk,
                                                    input logic [BKT_W-1:0] b);
    logic [BLK_W-1:0] s;
    s = blk >> (BLK_W - b);
    return NODE_W'(s) + root_node(b);
  endfunction

  function automatic logic [NODE_W-1:0] node_of_off(input logic [OFF_W-1:0] off,
                                                    input logic [BKT_W-1:0] b);
    logic [OFF_W-1:0] s;
    s = off >> (MAX_LOG2 - b);
    return NODE_W'(s) + root_node(b);
  endfunction

  function automatic logic [BLK_W-1:0] blk_of_node(input logic [NODE_W-1:0] i,
                                                   input logic [BKT_W-1:0] b);
    logic [NODE_W-1:0] rel;
    rel = i - root_node(b);
    rel = rel << (BLK_W - b);
    return rel[BLK_W-1:0];
  endfunction

  function automatic logic [BKT_W-1:0] bucket_of(input logic [SIZE_W-1:0] sz);
    logic [BKT_W-1:0] res;
    logic [SIZE_W:0]  cap;
    res = '0;
    for (int k = BUCKETS - 1; k >= 0; k--) begin
      cap = (SIZE_W+1)'(1) << (MIN_LOG2 + k);
      if ({1'b0, sz} <= cap) res = BKT_W'(BUCKETS - 1 - k);
    end
    return res;
  endfunction

endpackage

// File: rtl/bba_req_if.sv
// Request channel of the buddy block allocator: valid/ready plus payload.
// Depends on bba_pkg.
interface bba_req_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [SIZE_W-1:0] request_size;
  logic [OFF_W-1:0]  block_offset;

  modport source(output valid, action, request_size, block_offset, input ready);
  modport sink(input valid, action, request_size, block_offset, output ready);
endinterface

// File: rtl/bba_rsp_if.sv
// Response channel of the buddy block allocator: valid/ready plus payload.
// Depends on bba_pkg.
interface bba_rsp_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [OFF_W-1:0] granted_offset;

  modport source(output valid, status, granted_offset, input ready);
  modport sink(input valid, status, granted_offset, output ready);
endinterface

// File: rtl/bba_dpath.sv
// Datapath of the buddy block allocator: link and split flag memories,
// list heads, tree walk registers and result payload. Depends on bba_pkg.
module bba_dpath import bba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bba_cmd_t          cmd_i,
  output bba_stat_t         stat_o,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  input  logic              action_i,
  input  logic [SIZE_W-1:0] request_size_i,
  input  logic [OFF_W-1:0]  block_offset_i,
  output logic [1:0]        status_o,
  output logic [OFF_W-1:0]  granted_offset_o
);

  logic [NODE_W-1:0] link_prev_mem [NUM_BLOCKS];
  logic [NODE_W-1:0] link_next_mem [NUM_BLOCKS];
  logic              flag_mem      [NUM_BLOCKS];

  logic [NODE_W-1:0] head_prev_q [BUCKETS];
  logic [NODE_W-1:0] head_next_q [BUCKETS];

  logic [BKT_W-1:0]  rb_q;
  logic [SIZE_W-1:0] pool_limit_q;
  logic [BLK_W-1:0]  clr_cnt_q;

  logic              act_q;
  logic [SIZE_W-1:0] size_q;
  logic [BKT_W-1:0]  b_q, want_q, tgt_q, pb_q;
  logic [NODE_W-1:0] i_q;
  logic [BLK_W-1:0]  blk_q, pe_q, fa_q, rm_q;
  logic              flag_rd_q, flag_new_q;
  logic [NODE_W-1:0] lp_rd_q, ln_rd_q;
  logic [1:0]        res_status_q;
  logic [OFF_W-1:0]  res_offset_q;

  logic              pw_en, nw_en;
  logic [NODE_W-1:0] pw_node, pw_val, nw_node, nw_val;
  logic [NODE_W-1:0] tail, hd, pe_node;
  logic [NODE_W-1:0] i2, sib;
  logic [BKT_W-1:0]  ld_bkt;
  logic [CMP_W-1:0]  right, need_full, need, blk_off;

  assign tail    = head_prev_q[pb_q];
  assign hd      = head_node(pb_q);
  assign pe_node = {1'b0, pe_q};
  assign i2      = {i_q[NODE_W-2:0], 1'b1};
  assign sib     = ((i_q - 1'b1) ^ NODE_W'(1)) + 1'b1;
  assign ld_bkt  = bucket_of(request_size_i);

  // Route the two link write ports to block memory or head registers
  always_comb begin
    pw_en = 1'b0; pw_node = '0; pw_val = '0;
    nw_en = 1'b0; nw_node = '0; nw_val = '0;
    case (cmd_i.op)
      OP_CLEAR: begin
        if (clr_cnt_q == '0) begin
          pw_en = 1'b1; pw_val = head_node(BKT_W'(BUCKETS - 1));
          nw_en = 1'b1; nw_val = head_node(BKT_W'(BUCKETS - 1));
        end
      end
      OP_PUSH_A: begin
        pw_en = 1'b1; pw_node = pe_node; pw_val = tail;
        nw_en = 1'b1; nw_node = pe_node; nw_val = hd;
      end
      OP_PUSH_B: begin
        nw_en = 1'b1; nw_node = tail; nw_val = pe_node;
        pw_en = 1'b1; pw_node = hd;   pw_val = pe_node;
      end
      OP_INIT: begin
        pw_en = 1'b1; pw_node = hd; pw_val = hd;
        nw_en = 1'b1; nw_node = hd; nw_val = hd;
      end
      OP_RM_WR: begin
        nw_en = 1'b1; nw_node = lp_rd_q; nw_val = ln_rd_q;
        pw_en = 1'b1; pw_node = ln_rd_q; pw_val = lp_rd_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < BUCKETS; k++) begin
        if (k == BUCKETS - 1) begin
          head_prev_q[k] <= '0;
          head_next_q[k] <= '0;
        end else begin
          head_prev_q[k] <= head_node(BKT_W'(k));
          head_next_q[k] <= head_node(BKT_W'(k));
        end
      end
    end else begin
      for (int k = 0; k < BUCKETS; k++) begin
        if (pw_en && pw_node[NODE_W-1] && pw_node[BLK_W-1:0] == BLK_W'(k))
          head_prev_q[k] <= pw_val;
        if (nw_en && nw_node[NODE_W-1] && nw_node[BLK_W-1:0] == BLK_W'(k))
          head_next_q[k] <= nw_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pw_en && !pw_node[NODE_W-1]) link_prev_mem[pw_node[BLK_W-1:0]] <= pw_val;
    if (nw_en && !nw_node[NODE_W-1]) link_next_mem[nw_node[BLK_W-1:0]] <= nw_val;
    if (cmd_i.op == OP_RD_LINK) begin
      lp_rd_q <= link_prev_mem[rm_q];
      ln_rd_q <= link_next_mem[rm_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_CLEAR) flag_mem[clr_cnt_q] <= 1'b0;
    else if (cmd_i.op == OP_FLIP) flag_mem[fa_q] <= ~flag_rd_q;
    if (cmd_i.op == OP_RD_FLAG) flag_rd_q <= flag_mem[fa_q];
    if (cmd_i.op == OP_FLIP) flag_new_q <= ~flag_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rb_q         <= BKT_W'(BUCKETS - 1);
      pool_limit_q <= SPAN_BYTES;
      clr_cnt_q    <= '0;
    end else begin
      if (cfg_we_i) pool_limit_q <= cfg_wdata_i;
      if (cmd_i.op == OP_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.op == OP_G_DEC) rb_q <= rb_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        act_q  <= action_i;
        size_q <= request_size_i;
        b_q    <= ld_bkt;
        want_q <= ld_bkt;
        i_q    <= node_of_off(block_offset_i, ld_bkt);
      end
      OP_G_SETUP: begin
        fa_q <= parent_slot(root_node(rb_q));
        rm_q <= '0;
      end
      OP_G_SPLIT: begin
        pb_q <= rb_q;
        pe_q <= blk_of_node(root_node(rb_q) + 1'b1, rb_q);
      end
      OP_G_DEC: begin
        pb_q <= rb_q - 1'b1;
        pe_q <= '0;
        fa_q <= parent_slot(root_node(rb_q - 1'b1));
      end
      OP_A_TGT:  tgt_q <= b_q;
      OP_A_TGT2: tgt_q <= b_q - 1'b1;
      OP_B_DEC:  b_q   <= b_q - 1'b1;
      OP_A_POP: begin
        blk_q <= head_prev_q[b_q][BLK_W-1:0];
        rm_q  <= head_prev_q[b_q][BLK_W-1:0];
      end
      OP_A_UNDO: begin
        pb_q <= b_q;
        pe_q <= blk_q;
      end
      OP_A_NODE: begin
        i_q  <= node_of_blk(blk_q, b_q);
        fa_q <= parent_slot(node_of_blk(blk_q, b_q));
      end
      OP_A_SPLIT: begin
        i_q  <= i2;
        b_q  <= b_q + 1'b1;
        fa_q <= i_q[BLK_W-1:0];
        pb_q <= b_q + 1'b1;
        pe_q <= blk_of_node(i2 + 1'b1, b_q + 1'b1);
      end
      OP_F_SET: fa_q <= parent_slot(i_q);
      OP_F_SIB: rm_q <= blk_of_node(sib, b_q);
      OP_F_UP: begin
        i_q <= (i_q - 1'b1) >> 1;
        b_q <= b_q - 1'b1;
      end
      OP_F_END: begin
        pb_q <= b_q;
        pe_q <= blk_of_node(i_q, b_q);
      end
      OP_RESULT: begin
        res_status_q <= cmd_i.code;
        res_offset_q <= (cmd_i.code == RES_OK && !act_q) ?
                        {blk_q, {MIN_LOG2{1'b0}}} : '0;
      end
      default: begin
      end
    endcase
  end

  // Pool checks: a split right half needs room for its links, a grant its bytes
  assign right     = CMP_W'(1) << (MAX_LOG2 - rb_q);
  assign need_full = CMP_W'(1) << (MAX_LOG2 - b_q);
  assign need      = (b_q < want_q) ? (need_full >> 1) + CMP_W'(LINK_BYTES) : need_full;
  assign blk_off   = CMP_W'({blk_q, {MIN_LOG2{1'b0}}});

  always_comb begin
    stat_o.clr_last   = &clr_cnt_q;
    stat_o.big        = size_q > SPAN_BYTES;
    stat_o.act        = act_q;
    stat_o.grow_more  = tgt_q < rb_q;
    stat_o.flag_rd    = flag_rd_q;
    stat_o.right_fail = (right + CMP_W'(LINK_BYTES)) > CMP_W'(pool_limit_q);
    stat_o.root_nz    = rb_q != '0;
    stat_o.pop_empty  = head_prev_q[b_q][NODE_W-1];
    stat_o.b_zero     = b_q == '0;
    stat_o.b_is_root  = b_q == rb_q;
    stat_o.fit        = (blk_off + need) <= CMP_W'(pool_limit_q);
    stat_o.i_nz       = node_of_blk(blk_q, b_q) != '0;
    stat_o.b_lt_want  = b_q < want_q;
    stat_o.free_more  = (i_q != '0) && (b_q != '0);
    stat_o.flag_new   = flag_new_q;
  end

  assign status_o         = res_status_q;
  assign granted_offset_o = res_offset_q;

endmodule

// File: rtl/bba_ctrl.sv
// Sequencer of the buddy block allocator: walks grow, pop, split and merge
// steps and issues at most one datapath command per cycle. Depends on bba_pkg.
module bba_ctrl import bba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  input  bba_stat_t stat_i,
  output bba_cmd_t  cmd_o
);

  localparam int SW = 6;
  localparam logic [SW-1:0] ST_CLEAR   = 6'd0;
  localparam logic [SW-1:0] ST_IDLE    = 6'd1;
  localparam logic [SW-1:0] ST_DECODE  = 6'd2;
  localparam logic [SW-1:0] ST_DONE    = 6'd3;
  localparam logic [SW-1:0] ST_G_CHK   = 6'd4;
  localparam logic [SW-1:0] ST_G_RDF   = 6'd5;
  localparam logic [SW-1:0] ST_G_TST   = 6'd6;
  localparam logic [SW-1:0] ST_G_RMW   = 6'd7;
  localparam logic [SW-1:0] ST_G_DECN  = 6'd8;
  localparam logic [SW-1:0] ST_G_INITN = 6'd9;
  localparam logic [SW-1:0] ST_G_PAN   = 6'd10;
  localparam logic [SW-1:0] ST_G_PBN   = 6'd11;
  localparam logic [SW-1:0] ST_G_PAS   = 6'd12;
  localparam logic [SW-1:0] ST_G_PBS   = 6'd13;
  localparam logic [SW-1:0] ST_G_DECS  = 6'd14;
  localparam logic [SW-1:0] ST_G_INITS = 6'd15;
  localparam logic [SW-1:0] ST_G_RDF2  = 6'd16;
  localparam logic [SW-1:0] ST_G_FLIP2 = 6'd17;
  localparam logic [SW-1:0] ST_A_TOP   = 6'd18;
  localparam logic [SW-1:0] ST_A_POP   = 6'd19;
  localparam logic [SW-1:0] ST_A_POP2  = 6'd20;
  localparam logic [SW-1:0] ST_A_RML   = 6'd21;
  localparam logic [SW-1:0] ST_A_RMW   = 6'd22;
  localparam logic [SW-1:0] ST_A_CHK   = 6'd23;
  localparam logic [SW-1:0] ST_A_NODE  = 6'd24;
  localparam logic [SW-1:0] ST_A_FLIP  = 6'd25;
  localparam logic [SW-1:0] ST_A_UPA   = 6'd26;
  localparam logic [SW-1:0] ST_A_UPB   = 6'd27;
  localparam logic [SW-1:0] ST_A_SPL   = 6'd28;
  localparam logic [SW-1:0] ST_A_RDF3  = 6'd29;
  localparam logic [SW-1:0] ST_A_FLIP3 = 6'd30;
  localparam logic [SW-1:0] ST_A_PA3   = 6'd31;
  localparam logic [SW-1:0] ST_A_PB3   = 6'd32;
  localparam logic [SW-1:0] ST_F_TOP   = 6'd33;
  localparam logic [SW-1:0] ST_F_RDF   = 6'd34;
  localparam logic [SW-1:0] ST_F_FLIP  = 6'd35;
  localparam logic [SW-1:0] ST_F_CHK   = 6'd36;
  localparam logic [SW-1:0] ST_F_RML   = 6'd37;
  localparam logic [SW-1:0] ST_F_RMW   = 6'd38;
  localparam logic [SW-1:0] ST_F_UP    = 6'd39;
  localparam logic [SW-1:0] ST_F_PA    = 6'd40;
  localparam logic [SW-1:0] ST_F_PB    = 6'd41;

  logic [SW-1:0] state_q, state_d;
  logic [1:0]    code_q, code_d;
  logic          ret_q, ret_d;
  logic          rsp_valid_q, rsp_valid_d;

  always_comb begin
    state_d     = state_q;
    code_d      = code_q;
    ret_d       = ret_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    cmd_o.op    = OP_IDLE;
    cmd_o.code  = code_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat_i.big) begin
          code_d  = stat_i.act ? RES_BAD_LEN : RES_TOO_BIG;
          state_d = ST_DONE;
        end else begin
          state_d = stat_i.act ? ST_F_TOP : ST_A_TOP;
        end
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.op    = OP_RESULT;
          rsp_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      // grow the root down toward the target bucket
      ST_G_CHK: begin
        if (stat_i.grow_more) begin
          cmd_o.op = OP_G_SETUP;
          state_d  = ST_G_RDF;
        end else begin
          state_d = ret_q ? ST_A_POP2 : ST_A_POP;
        end
      end
      ST_G_RDF: begin
        cmd_o.op = OP_RD_FLAG;
        state_d  = ST_G_TST;
      end
      ST_G_TST: begin
        if (!stat_i.flag_rd) begin
          cmd_o.op = OP_RD_LINK;
          state_d  = ST_G_RMW;
        end else if (stat_i.right_fail) begin
          code_d  = RES_NO_SPACE;
          state_d = ST_DONE;
        end else begin
          cmd_o.op = OP_G_SPLIT;
          state_d  = ST_G_PAS;
        end
      end
      ST_G_RMW:   begin cmd_o.op = OP_RM_WR;  state_d = ST_G_DECN;  end
      ST_G_DECN:  begin cmd_o.op = OP_G_DEC;  state_d = ST_G_INITN; end
      ST_G_INITN: begin cmd_o.op = OP_INIT;   state_d = ST_G_PAN;   end
      ST_G_PAN:   begin cmd_o.op = OP_PUSH_A; state_d = ST_G_PBN;   end
      ST_G_PBN:   begin cmd_o.op = OP_PUSH_B; state_d = ST_G_CHK;   end
      ST_G_PAS:   begin cmd_o.op = OP_PUSH_A; state_d = ST_G_PBS;   end
      ST_G_PBS:   begin cmd_o.op = OP_PUSH_B; state_d = ST_G_DECS;  end
      ST_G_DECS:  begin cmd_o.op = OP_G_DEC;  state_d = ST_G_INITS; end
      ST_G_INITS: begin
        cmd_o.op = OP_INIT;
        state_d  = stat_i.root_nz ? ST_G_RDF2 : ST_G_CHK;
      end
      ST_G_RDF2:  begin cmd_o.op = OP_RD_FLAG; state_d = ST_G_FLIP2; end
      ST_G_FLIP2: begin cmd_o.op = OP_FLIP;    state_d = ST_G_CHK;   end
      // allocate
      ST_A_TOP: begin
        cmd_o.op = OP_A_TGT;
        ret_d    = 1'b0;
        state_d  = ST_G_CHK;
      end
      ST_A_POP: begin
        if (!stat_i.pop_empty) begin
          cmd_o.op = OP_A_POP;
          state_d  = ST_A_RML;
        end else if (!stat_i.b_is_root || stat_i.b_zero) begin
          if (stat_i.b_zero) begin
            code_d  = RES_NO_SPACE;
            state_d = ST_DONE;
          end else begin
            cmd_o.op = OP_B_DEC;
            state_d  = ST_A_TOP;
          end
        end else begin
          cmd_o.op = OP_A_TGT2;
          ret_d    = 1'b1;
          state_d  = ST_G_CHK;
        end
      end
      ST_A_POP2: begin
        if (!stat_i.pop_empty) begin
          cmd_o.op = OP_A_POP;
          state_d  = ST_A_RML;
        end else begin
          code_d  = RES_NO_SPACE;
          state_d = ST_DONE;
        end
      end
      ST_A_RML: begin cmd_o.op = OP_RD_LINK; state_d = ST_A_RMW; end
      ST_A_RMW: begin cmd_o.op = OP_RM_WR;   state_d = ST_A_CHK; end
      ST_A_CHK: begin
        if (stat_i.fit) begin
          cmd_o.op = OP_A_NODE;
          state_d  = ST_A_NODE;
        end else begin
          cmd_o.op = OP_A_UNDO;
          state_d  = ST_A_UPA;
        end
      end
      ST_A_UPA: begin cmd_o.op = OP_PUSH_A; state_d = ST_A_UPB; end
      ST_A_UPB: begin
        cmd_o.op = OP_PUSH_B;
        code_d   = RES_NO_SPACE;
        state_d  = ST_DONE;
      end
      ST_A_NODE: begin
        if (stat_i.i_nz) begin
          cmd_o.op = OP_RD_FLAG;
          state_d  = ST_A_FLIP;
        end else begin
          state_d = ST_A_SPL;
        end
      end
      ST_A_FLIP: begin cmd_o.op = OP_FLIP; state_d = ST_A_SPL; end
      ST_A_SPL: begin
        if (stat_i.b_lt_want) begin
          cmd_o.op = OP_A_SPLIT;
          state_d  = ST_A_RDF3;
        end else begin
          code_d  = RES_OK;
          state_d = ST_DONE;
        end
      end
      ST_A_RDF3:  begin cmd_o.op = OP_RD_FLAG; state_d = ST_A_FLIP3; end
      ST_A_FLIP3: begin cmd_o.op = OP_FLIP;    state_d = ST_A_PA3;   end
      ST_A_PA3:   begin cmd_o.op = OP_PUSH_A;  state_d = ST_A_PB3;   end
      ST_A_PB3:   begin cmd_o.op = OP_PUSH_B;  state_d = ST_A_SPL;   end
      // free and merge
      ST_F_TOP: begin
        if (stat_i.free_more) begin
          cmd_o.op = OP_F_SET;
          state_d  = ST_F_RDF;
        end else begin
          cmd_o.op = OP_F_END;
          state_d  = ST_F_PA;
        end
      end
      ST_F_RDF:  begin cmd_o.op = OP_RD_FLAG; state_d = ST_F_FLIP; end
      ST_F_FLIP: begin cmd_o.op = OP_FLIP;    state_d = ST_F_CHK;  end
      ST_F_CHK: begin
        if (stat_i.flag_new || stat_i.b_is_root) begin
          cmd_o.op = OP_F_END;
          state_d  = ST_F_PA;
        end else begin
          cmd_o.op = OP_F_SIB;
          state_d  = ST_F_RML;
        end
      end
      ST_F_RML: begin cmd_o.op = OP_RD_LINK; state_d = ST_F_RMW; end
      ST_F_RMW: begin cmd_o.op = OP_RM_WR;   state_d = ST_F_UP;  end
      ST_F_UP:  begin cmd_o.op = OP_F_UP;    state_d = ST_F_TOP; end
      ST_F_PA:  begin cmd_o.op = OP_PUSH_A;  state_d = ST_F_PB;  end
      ST_F_PB: begin
        cmd_o.op = OP_PUSH_B;
        code_d   = RES_OK;
        state_d  = ST_DONE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      code_q      <= RES_OK;
      ret_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      code_q      <= code_d;
      ret_q       <= ret_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign req_ready_o = state_q == ST_IDLE;
  assign rsp_valid_o = rsp_valid_q;

endmodule

// File: rtl/buddy_block_allocator_unit.sv
// Buddy block allocator: one transaction in, one result transaction out.
// Throughput: one request at a time, the next taken the cycle after the result loads.
// Reset: a clear pass over all 4096 split flags runs first; pool_limit returns to 65536.
module buddy_block_allocator_unit import bba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  bba_req_if.sink           req_i,
  bba_rsp_if.source         rsp_o
);

  bba_cmd_t  cmd;
  bba_stat_t stat;

  // Sequencer: at most one datapath command per cycle, holds the result until taken
  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Memories, list heads, root bucket, pool limit and result payload
  bba_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .action_i         (req_i.action),
    .request_size_i   (req_i.request_size),
    .block_offset_i   (req_i.block_offset),
    .status_o         (rsp_o.status),
    .granted_offset_o (rsp_o.granted_offset)
  );

endmodule
